/* hdl/atcb_pkg.sv */
// Package for the ATA task-file command builder.
// Holds field widths, register and opcode codes, reset values and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atcb_pkg;

  // Field widths.
  localparam int unsigned AddrW   = 28;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HeadW   = 5;
  localparam int unsigned CylW    = 16;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CfgIdxW = 3;

  // Divider pipeline shape: quotient bits resolved per stage, and stage count.
  localparam int unsigned StageBits = 4;
  localparam int unsigned NumStages = AddrW / StageBits;

  // Request kinds; anything else is a bad command.
  localparam logic [ReqW-1:0] ReqRead  = 2'd0;
  localparam logic [ReqW-1:0] ReqWrite = 2'd1;

  // Task-file register indexes, in the order they are written.
  localparam logic [IdxW-1:0] RegControl = 3'd0;
  localparam logic [IdxW-1:0] RegCount   = 3'd1;
  localparam logic [IdxW-1:0] RegSector  = 3'd2;
  localparam logic [IdxW-1:0] RegCylLow  = 3'd3;
  localparam logic [IdxW-1:0] RegCylHigh = 3'd4;
  localparam logic [IdxW-1:0] RegSelect  = 3'd5;
  localparam logic [IdxW-1:0] RegCommand = 3'd6;
  localparam logic [IdxW-1:0] RegNone    = 3'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgUseLba      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSectPerTrk  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHeads       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSelectBase  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgControlByte = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMultCount   = 3'd5;

  // Command opcodes.
  localparam logic [ByteW-1:0] OpRead       = 8'h20;
  localparam logic [ByteW-1:0] OpReadMulti  = 8'hC4;
  localparam logic [ByteW-1:0] OpWrite      = 8'h30;
  localparam logic [ByteW-1:0] OpWriteMulti = 8'hC5;

  // Configuration reset values.
  localparam logic             RstUseLba      = 1'b0;
  localparam logic [ByteW-1:0] RstSectPerTrk  = 8'd63;
  localparam logic [HeadW-1:0] RstHeads       = 5'd16;
  localparam logic [ByteW-1:0] RstSelectBase  = 8'd160;
  localparam logic [ByteW-1:0] RstControlByte = 8'd8;
  localparam logic [ByteW-1:0] RstMultCount   = 8'd0;

  // Configuration bundle; divisors are stored with zero already mapped to one.
  typedef struct packed {
    logic             use_lba;
    logic [ByteW-1:0] sect_per_trk;
    logic [HeadW-1:0] heads;
    logic [ByteW-1:0] select_base;
    logic [ByteW-1:0] control_byte;
    logic [ByteW-1:0] multi_cnt;
  } cfg_t;

  // One request as it travels through the divider pipeline.
  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [AddrW-1:0] block;
    logic [ByteW-1:0] sector_count;
    logic [ByteW-1:0] rem_sect;
    logic [HeadW-1:0] rem_head;
    logic [CylW-1:0]  cyl;
  } item_t;

endpackage

`default_nettype wire

/* hdl/atcb_div_stage.sv */
// One stage of the CHS divider pipeline: four restoring steps of both divisions.
// Depends on atcb_pkg for the item type and widths.
`timescale 1ns / 1ps
`default_nettype none

module atcb_div_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire atcb_pkg::item_t               in_item_i,
  input  wire logic [atcb_pkg::StageBits-1:0] blk_bits_i,
  input  wire logic [atcb_pkg::ByteW-1:0]     spt_i,
  input  wire logic [atcb_pkg::HeadW-1:0]     nh_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      atcb_pkg::item_t               out_item_o
);

  logic            valid_q, valid_d;
  atcb_pkg::item_t item_q, item_d;

  // Sector division feeds its quotient bits, MSB first, straight into the
  // head division, so the track number is never stored.
  always_comb begin
    logic [atcb_pkg::ByteW:0] t_sect;
    logic [atcb_pkg::HeadW:0] t_head;
    logic                     q_bit;
    item_d = in_item_i;
    for (int j = 0; j < atcb_pkg::StageBits; j++) begin
      t_sect = {item_d.rem_sect, blk_bits_i[atcb_pkg::StageBits-1-j]};
      if (t_sect >= {1'b0, spt_i}) begin
        item_d.rem_sect = atcb_pkg::ByteW'(t_sect - {1'b0, spt_i});
        q_bit           = 1'b1;
      end else begin
        item_d.rem_sect = t_sect[atcb_pkg::ByteW-1:0];
        q_bit           = 1'b0;
      end
      t_head = {item_d.rem_head, q_bit};
      if (t_head >= {1'b0, nh_i}) begin
        item_d.rem_head = atcb_pkg::HeadW'(t_head - {1'b0, nh_i});
        item_d.cyl      = {item_d.cyl[atcb_pkg::CylW-2:0], 1'b1};
      end else begin
        item_d.rem_head = t_head[atcb_pkg::HeadW-1:0];
        item_d.cyl      = {item_d.cyl[atcb_pkg::CylW-2:0], 1'b0};
      end
    end
  end

  // The stage takes a new transaction when empty or when its content moves on.
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

/* hdl/atcb_divider.sv */
// Chain of divider stages that resolves sector, head and cylinder for CHS mode.
// Depends on atcb_pkg and atcb_div_stage.
`timescale 1ns / 1ps
`default_nettype none

module atcb_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire atcb_pkg::item_t           in_item_i,
  input  wire logic [atcb_pkg::ByteW-1:0] spt_i,
  input  wire logic [atcb_pkg::HeadW-1:0] nh_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      atcb_pkg::item_t           out_item_o
);

  logic            valid_c [atcb_pkg::NumStages+1];
  logic            ready_c [atcb_pkg::NumStages+1];
  atcb_pkg::item_t item_c  [atcb_pkg::NumStages+1];

  assign valid_c[0]  = in_valid_i;
  assign item_c[0]   = in_item_i;
  assign in_ready_o  = ready_c[0];

  // Stage s consumes the next StageBits address bits, most significant first.
  for (genvar s = 0; s < atcb_pkg::NumStages; s++) begin : g_stage
    atcb_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_c[s]),
      .in_ready_o  (ready_c[s]),
      .in_item_i   (item_c[s]),
      .blk_bits_i  (item_c[s].block[atcb_pkg::AddrW-1-atcb_pkg::StageBits*s -:
                                    atcb_pkg::StageBits]),
      .spt_i       (spt_i),
      .nh_i        (nh_i),
      .out_valid_o (valid_c[s+1]),
      .out_ready_i (ready_c[s+1]),
      .out_item_o  (item_c[s+1])
    );
  end

  assign ready_c[atcb_pkg::NumStages] = out_ready_i;
  assign out_valid_o = valid_c[atcb_pkg::NumStages];
  assign out_item_o  = item_c[atcb_pkg::NumStages];

endmodule

`default_nettype wire

/* hdl/atcb_emitter.sv */
// Holds one finished request and emits its seven register writes, one a cycle while the receiver is ready.
// Depends on atcb_pkg for codes, opcodes and the item and config types.
`timescale 1ns / 1ps
`default_nettype none

module atcb_emitter (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire atcb_pkg::cfg_t           cfg_i,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire atcb_pkg::item_t          in_item_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic [atcb_pkg::IdxW-1:0]  reg_index_o,
  output      logic [atcb_pkg::ByteW-1:0] reg_value_o,
  output      logic                     bad_command_o,
  output      logic                     last_write_o
);

  logic                        item_vld_q, item_vld_d;
  atcb_pkg::item_t             item_q;
  logic [atcb_pkg::IdxW-1:0]   beat_q, beat_d;
  logic                        out_vld_q, out_vld_d;
  logic [atcb_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [atcb_pkg::ByteW-1:0]  val_q, val_d;
  logic                        bad_q, bad_d;
  logic                        last_q, last_d;
  logic                        load;
  logic                        last_beat;
  logic                        bad;
  logic [atcb_pkg::ByteW-1:0]  sect_v, lcyl_v, hcyl_v, sel_v, op_v;

  // A result moves into the output register whenever that register is free.
  assign load       = item_vld_q && (!out_vld_q || out_ready_i);
  assign last_beat  = (beat_q == atcb_pkg::RegCommand);
  assign in_ready_o = !item_vld_q || (load && last_beat);

  // Address bytes for the two addressing modes.
  always_comb begin
    if (cfg_i.use_lba) begin
      sect_v = item_q.block[7:0];
      lcyl_v = item_q.block[15:8];
      hcyl_v = item_q.block[23:16];
      sel_v  = {4'b0000, item_q.block[27:24]} | cfg_i.select_base;
    end else begin
      sect_v = atcb_pkg::ByteW'(item_q.rem_sect + 8'd1);
      lcyl_v = item_q.cyl[7:0];
      hcyl_v = item_q.cyl[15:8];
      sel_v  = {3'b000, item_q.rem_head} | cfg_i.select_base;
    end
  end

  // Opcode choice: multiple-sector commands when a multiple count is set.
  always_comb begin
    bad = 1'b0;
    case (item_q.req_type)
      atcb_pkg::ReqRead: begin
        op_v = (cfg_i.multi_cnt != 8'd0) ? atcb_pkg::OpReadMulti : atcb_pkg::OpRead;
      end
      atcb_pkg::ReqWrite: begin
        op_v = (cfg_i.multi_cnt != 8'd0) ? atcb_pkg::OpWriteMulti : atcb_pkg::OpWrite;
      end
      default: begin
        op_v = 8'd0;
        bad  = 1'b1;
      end
    endcase
  end

  // Result for the current beat.
  always_comb begin
    idx_d  = beat_q;
    bad_d  = bad;
    last_d = 1'b0;
    unique case (beat_q)
      atcb_pkg::RegControl: val_d = cfg_i.control_byte;
      atcb_pkg::RegCount:   val_d = item_q.sector_count;
      atcb_pkg::RegSector:  val_d = sect_v;
      atcb_pkg::RegCylLow:  val_d = lcyl_v;
      atcb_pkg::RegCylHigh: val_d = hcyl_v;
      atcb_pkg::RegSelect:  val_d = sel_v;
      atcb_pkg::RegCommand: begin
        last_d = 1'b1;
        val_d  = op_v;
        if (bad) begin
          idx_d = atcb_pkg::RegNone;
        end
      end
      default: val_d = 8'd0;
    endcase
  end

  // Beat counter, item slot and output register control.
  always_comb begin
    beat_d     = beat_q;
    item_vld_d = item_vld_q;
    out_vld_d  = out_vld_q;
    if (load) begin
      beat_d    = last_beat ? atcb_pkg::RegControl : atcb_pkg::IdxW'(beat_q + 3'd1);
      out_vld_d = 1'b1;
      if (last_beat) begin
        item_vld_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      item_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q     <= atcb_pkg::RegControl;
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      beat_q     <= beat_d;
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    if (load) begin
      idx_q  <= idx_d;
      val_q  <= val_d;
      bad_q  <= bad_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign reg_index_o   = idx_q;
  assign reg_value_o   = val_q;
  assign bad_command_o = bad_q;
  assign last_write_o  = last_q;

endmodule

`default_nettype wire

/* hdl/ata_taskfile_command_builder.sv */
// ATA task-file command builder, top level.
// Depends on atcb_pkg, atcb_divider and atcb_emitter.
//
// Usage: a request (req_type, block_address, sector_count) enters on the input
// valid/ready channel. Each request yields seven register-write transactions on
// the output channel: control, count, sector, cylinder low, cylinder high,
// drive/head, and then the command opcode (or index 7 with value 0 for a bad
// request kind); last_write_o marks the seventh.
// Path: an accepted request passes the seven divider stages, the emitter's item
// slot and its output register; the seven results then follow one per cycle
// while out_ready_i is high. A request is taken every cycle while in_ready_o is
// high into the 7-stage divider pipeline, but the sustained rate is set by the
// single output port that emits one register write per cycle. The next request
// is accepted while results of the previous one are still waiting.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i; 6 and 7 are
// ignored. Users write only while the block is idle; it does not enforce this.
// Reset: all configuration registers return to their defaults and the pipeline
// and output register are emptied. When the receiver stalls, the current result
// holds and the pipeline fills, then in_ready_o drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module ata_taskfile_command_builder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [atcb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [atcb_pkg::ByteW-1:0]   cfg_data_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [atcb_pkg::ReqW-1:0]    req_type_i,
  input  wire logic [atcb_pkg::AddrW-1:0]   block_address_i,
  input  wire logic [atcb_pkg::ByteW-1:0]   sector_count_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [atcb_pkg::IdxW-1:0]    reg_index_o,
  output      logic [atcb_pkg::ByteW-1:0]   reg_value_o,
  output      logic                         bad_command_o,
  output      logic                         last_write_o
);

  atcb_pkg::cfg_t  cfg_q, cfg_d;
  atcb_pkg::item_t in_item;
  logic            div_valid, div_ready;
  atcb_pkg::item_t div_item;

  // Configuration writes. A zero divisor acts as one, so it is stored as one.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atcb_pkg::CfgUseLba:      cfg_d.use_lba      = cfg_data_i[0];
        atcb_pkg::CfgSectPerTrk: begin
          cfg_d.sect_per_trk = (cfg_data_i == 8'd0) ? 8'd1 : cfg_data_i;
        end
        atcb_pkg::CfgHeads: begin
          cfg_d.heads = (cfg_data_i[atcb_pkg::HeadW-1:0] == 5'd0) ?
                        5'd1 : cfg_data_i[atcb_pkg::HeadW-1:0];
        end
        atcb_pkg::CfgSelectBase:  cfg_d.select_base  = cfg_data_i;
        atcb_pkg::CfgControlByte: cfg_d.control_byte = cfg_data_i;
        atcb_pkg::CfgMultCount:   cfg_d.multi_cnt    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_lba      <= atcb_pkg::RstUseLba;
      cfg_q.sect_per_trk <= atcb_pkg::RstSectPerTrk;
      cfg_q.heads        <= atcb_pkg::RstHeads;
      cfg_q.select_base  <= atcb_pkg::RstSelectBase;
      cfg_q.control_byte <= atcb_pkg::RstControlByte;
      cfg_q.multi_cnt    <= atcb_pkg::RstMultCount;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Incoming request with cleared division state.
  always_comb begin
    in_item              = '0;
    in_item.req_type     = req_type_i;
    in_item.block        = block_address_i;
    in_item.sector_count = sector_count_i;
  end

  atcb_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .spt_i       (cfg_q.sect_per_trk),
    .nh_i        (cfg_q.heads),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_item_o  (div_item)
  );

  atcb_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (div_valid),
    .in_ready_o    (div_ready),
    .in_item_i     (div_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reg_index_o   (reg_index_o),
    .reg_value_o   (reg_value_o),
    .bad_command_o (bad_command_o),
    .last_write_o  (last_write_o)
  );

  // Only the command slot, or the empty slot of a bad request, ends a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_write_o) |->
      (reg_index_o == atcb_pkg::RegCommand || reg_index_o == atcb_pkg::RegNone))
    else $error("last write on a register other than command or none");

  // The empty slot always carries value zero and the bad-command flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reg_index_o == atcb_pkg::RegNone) |->
      (bad_command_o && last_write_o && reg_value_o == 8'd0))
    else $error("empty slot with wrong value or flags");

  // Within a run, results follow back to back in register order; a bad request
  // ends on the empty slot in place of the command register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_write_o) |=>
      (out_valid_o && (reg_index_o == $past(reg_index_o) + 3'd1 ||
                       reg_index_o == atcb_pkg::RegNone)))
    else $error("register writes of a run out of order or interrupted");

  // A new run always starts at the control register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_write_o) |=>
      (!out_valid_o || reg_index_o == atcb_pkg::RegControl))
    else $error("run did not start with the control register");

endmodule

`default_nettype wire

/* sim/atcb_tf_checker.sv */
// Scoreboard for the ATA task-file command builder.
// Predicts the seven register writes of every accepted request and checks them in order.
// Depends on atcb_pkg.
`timescale 1ns / 1ps

module atcb_tf_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [atcb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [atcb_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [atcb_pkg::ReqW-1:0]    req_type_i,
  input  logic [atcb_pkg::AddrW-1:0]   block_address_i,
  input  logic [atcb_pkg::ByteW-1:0]   sector_count_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [atcb_pkg::IdxW-1:0]    reg_index_i,
  input  logic [atcb_pkg::ByteW-1:0]   reg_value_i,
  input  logic                         bad_command_i,
  input  logic                         last_write_i,
  output int                           pending_o,
  output int                           fail_count_o
);

  import atcb_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [ByteW-1:0] value;
    logic             bad;
    logic             last;
  } tf_write_t;

  tf_write_t expected_writes[$];
  int        fail_total = 0;

  // Shadow copy of the configuration registers.
  logic             lba_mode;
  logic [ByteW-1:0] spt_reg;
  logic [HeadW-1:0] heads_reg;
  logic [ByteW-1:0] select_reg;
  logic [ByteW-1:0] control_reg;
  logic [ByteW-1:0] mult_reg;

  function automatic void push_write(logic [IdxW-1:0] idx, logic [ByteW-1:0] value,
                                     logic bad, logic last);
    tf_write_t w;
    w.idx   = idx;
    w.value = value;
    w.bad   = bad;
    w.last  = last;
    expected_writes.push_back(w);
  endfunction

  // Work out the whole run of task-file writes that one request starts.
  function automatic void predict_task_file_run(logic [ReqW-1:0] kind,
                                                logic [AddrW-1:0] blk,
                                                logic [ByteW-1:0] cnt);
    int unsigned spt;
    int unsigned nh;
    int unsigned track;
    int unsigned cyl;
    int unsigned tmp;
    logic [ByteW-1:0] sect_b;
    logic [ByteW-1:0] cyl_lo;
    logic [ByteW-1:0] cyl_hi;
    logic [ByteW-1:0] sel_b;
    logic             bad;
    bad = (kind != ReqRead) && (kind != ReqWrite);
    if (lba_mode) begin
      sect_b = blk[7:0];
      cyl_lo = blk[15:8];
      cyl_hi = blk[23:16];
      sel_b  = {4'h0, blk[27:24]} | select_reg;
    end else begin
      // A zero divisor behaves as one; the cylinder keeps only 16 bits.
      spt    = (spt_reg == 0) ? 1 : spt_reg;
      nh     = (heads_reg == 0) ? 1 : heads_reg;
      track  = blk / spt;
      cyl    = (track / nh) & 32'h0000_FFFF;
      tmp    = blk % spt + 1;
      sect_b = tmp[7:0];
      cyl_lo = cyl[7:0];
      cyl_hi = cyl[15:8];
      // The head number is merged unmasked, so large head counts reach bit 4.
      tmp    = track % nh;
      sel_b  = tmp[7:0] | select_reg;
    end
    push_write(RegControl, control_reg, bad, 1'b0);
    push_write(RegCount,   cnt,         bad, 1'b0);
    push_write(RegSector,  sect_b,      bad, 1'b0);
    push_write(RegCylLow,  cyl_lo,      bad, 1'b0);
    push_write(RegCylHigh, cyl_hi,      bad, 1'b0);
    push_write(RegSelect,  sel_b,       bad, 1'b0);
    case (kind)
      ReqRead: begin
        push_write(RegCommand, (mult_reg != 0) ? OpReadMulti : OpRead, 1'b0, 1'b1);
      end
      ReqWrite: begin
        push_write(RegCommand, (mult_reg != 0) ? OpWriteMulti : OpWrite, 1'b0, 1'b1);
      end
      default: begin
        push_write(RegNone, '0, 1'b1, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      fail_total++;
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
    end
  endfunction

  // Compare result transactions first, then record new requests and register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    tf_write_t want;
    if (!rst_ni) begin
      expected_writes.delete();
      lba_mode    = RstUseLba;
      spt_reg     = RstSectPerTrk;
      heads_reg   = RstHeads;
      select_reg  = RstSelectBase;
      control_reg = RstControlByte;
      mult_reg    = RstMultCount;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_writes.size() == 0) begin
          fail_total++;
          $error("register write with no request outstanding: index %0d value %0h",
                 reg_index_i, reg_value_i);
        end else begin
          want = expected_writes.pop_front();
          check_field("reg_index",   want.idx,   reg_index_i);
          check_field("reg_value",   want.value, reg_value_i);
          check_field("bad_command", want.bad,   bad_command_i);
          check_field("last_write",  want.last,  last_write_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_task_file_run(req_type_i, block_address_i, sector_count_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgUseLba:      lba_mode    = cfg_data_i[0];
          CfgSectPerTrk:  spt_reg     = cfg_data_i;
          CfgHeads:       heads_reg   = cfg_data_i[HeadW-1:0];
          CfgSelectBase:  select_reg  = cfg_data_i;
          CfgControlByte: control_reg = cfg_data_i;
          CfgMultCount:   mult_reg    = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_writes.size();
    end
  end

  assign fail_count_o = fail_total;

endmodule

/* sim/tb_ata_taskfile_command_builder.sv */
// Testbench top for the ATA task-file command builder.
// Drives requests and geometry settings; the checker in atcb_tf_checker.sv judges results.
// Depends on atcb_pkg, ata_taskfile_command_builder and atcb_tf_checker.
`timescale 1ns / 1ps

module tb_ata_taskfile_command_builder;

  import atcb_pkg::*;

  // Request kinds that the block must reject.
  localparam logic [ReqW-1:0] ReqBadLow  = 2'd2;
  localparam logic [ReqW-1:0] ReqBadHigh = 2'd3;

  localparam int IdlePct     = 14;
  localparam int ItemsPerSet = 34;
  localparam int NumSets     = 6;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 16;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = '0;
  logic [ByteW-1:0]  cfg_data_i      = '0;
  logic              in_valid_i      = 1'b0;
  logic [ReqW-1:0]   req_type_i      = '0;
  logic [AddrW-1:0]  block_address_i = '0;
  logic [ByteW-1:0]  sector_count_i  = '0;
  logic              out_ready_i     = 1'b0;
  logic              idle_on         = 1'b1;

  logic              in_ready_o;
  logic              out_valid_o;
  logic [IdxW-1:0]   reg_index_o;
  logic [ByteW-1:0]  reg_value_o;
  logic              bad_command_o;
  logic              last_write_o;

  int                pending_writes;
  int                fail_total;
  int                quiet_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ata_taskfile_command_builder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .block_address_i(block_address_i),
    .sector_count_i (sector_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reg_index_o    (reg_index_o),
    .reg_value_o    (reg_value_o),
    .bad_command_o  (bad_command_o),
    .last_write_o   (last_write_o)
  );

  atcb_tf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .req_type_i     (req_type_i),
    .block_address_i(block_address_i),
    .sector_count_i (sector_count_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reg_index_i    (reg_index_o),
    .reg_value_i    (reg_value_o),
    .bad_command_i  (bad_command_o),
    .last_write_i   (last_write_o),
    .pending_o      (pending_writes),
    .fail_count_o   (fail_total)
  );

  // The receiver stalls at random unless idling is switched off.
  always @(posedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(99) >= IdlePct);
  end

  // Watchdog: end the run when no transaction of any kind moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Write all six registers, one per cycle; only called while the block is idle.
  task automatic load_config(input logic lba, input logic [7:0] spt, input logic [7:0] hd,
                             input logic [7:0] sel, input logic [7:0] ctl,
                             input logic [7:0] mc);
    logic [CfgIdxW-1:0] idxs[6];
    logic [ByteW-1:0]   vals[6];
    idxs = '{CfgUseLba, CfgSectPerTrk, CfgHeads, CfgSelectBase, CfgControlByte,
             CfgMultCount};
    vals = '{{7'h00, lba}, spt, hd, sel, ctl, mc};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offer one request, with optional idle cycles ahead of it, until it is accepted.
  task automatic send_request(input logic [ReqW-1:0] kind, input logic [AddrW-1:0] blk,
                              input logic [ByteW-1:0] cnt);
    while (idle_on && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    block_address_i <= blk;
    sector_count_i  <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering requests and wait until every expected write has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] rand_block();
    logic [31:0] r;
    case ($urandom_range(9))
      0:       r = 32'd0;
      1:       r = 32'h0FFF_FFFF;
      2, 3:    r = $urandom_range(4095);
      default: r = $urandom();
    endcase
    return r[AddrW-1:0];
  endfunction

  function automatic logic [ReqW-1:0] rand_kind();
    int r;
    r = $urandom_range(99);
    if (r < 45) return ReqRead;
    if (r < 90) return ReqWrite;
    return $urandom_range(1) ? ReqBadHigh : ReqBadLow;
  endfunction

  initial begin
    logic [7:0] spt;
    logic [7:0] hd;
    logic [7:0] mc;
    logic [7:0] junk;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: CHS with 63 sectors and 16 heads.
    send_request(ReqRead,    28'h000_0000, 8'h00);
    send_request(ReqWrite,   28'hFFF_FFFF, 8'hFF);
    send_request(ReqBadLow,  28'h123_4567, 8'h5A);
    send_request(ReqBadHigh, 28'hEDC_BA98, 8'hA5);
    wait_drained();

    // LBA addressing, multiple commands on.
    load_config(1'b1, 8'd63, 8'd16, 8'hE0, 8'h00, 8'd1);
    send_request(ReqRead,    28'hFFF_FFFF, 8'h01);
    send_request(ReqWrite,   28'hABC_DEF1, 8'h80);
    send_request(ReqRead,    28'h000_0000, 8'h7F);
    send_request(ReqBadHigh, 28'h5A5_A5A5, 8'h00);
    wait_drained();

    // Zero divisors act as one, so the cylinder is truncated to 16 bits.
    load_config(1'b0, 8'd0, 8'd0, 8'hA0, 8'hFF, 8'hFF);
    send_request(ReqRead,    28'hFFF_FFFF, 8'h10);
    send_request(ReqWrite,   28'h000_3039, 8'h20);
    send_request(ReqBadLow,  28'h0FF_FFFF, 8'h40);
    wait_drained();

    // Largest divisors, with a head count above sixteen and junk above the head bits.
    load_config(1'b0, 8'd255, 8'hFF, 8'h00, 8'h55, 8'd0);
    send_request(ReqRead,    28'hFFF_FFFF, 8'hAA);
    send_request(ReqWrite,   28'h7FF_FFFE, 8'h55);
    send_request(ReqRead,    28'h000_00FE, 8'hC3);
    wait_drained();

    // Smallest nonzero divisors.
    load_config(1'b0, 8'd1, 8'd1, 8'hFF, 8'h08, 8'd0);
    send_request(ReqWrite,   28'hFFF_FFFF, 8'hFF);
    send_request(ReqRead,    28'h001_0000, 8'h01);
    wait_drained();

    // Random requests under a series of random settings; one set runs with no idling.
    for (int s = 0; s < NumSets; s++) begin
      case ($urandom_range(5))
        0:       spt = 8'd0;
        1:       spt = 8'd1;
        2:       spt = 8'd255;
        default: spt = $urandom_range(255);
      endcase
      junk = $urandom_range(255);
      case ($urandom_range(5))
        0:       hd = {junk[7:5], 5'd0};
        1:       hd = {junk[7:5], 5'd16};
        2:       hd = {junk[7:5], 5'd31};
        default: hd = {junk[7:5], 5'($urandom_range(1, 16))};
      endcase
      mc = $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 255));
      idle_on <= (s != 3);
      load_config(s[0], spt, hd, 8'($urandom_range(255)), 8'($urandom_range(255)), mc);
      for (int n = 0; n < ItemsPerSet; n++) begin
        send_request(rand_kind(), rand_block(), 8'($urandom_range(255)));
      end
      wait_drained();
    end

    if (fail_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
